FILE: hdl/sobel_pkg.sv
// Package for the Sobel edge byte stream filter.
// Holds the transfer payload types, register indexes and arithmetic constants.
// No dependencies.
package sobel_pkg;

    localparam int MAX_WIDTH_DEF       = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DO_HORIZONTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DO_VERTICAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SIGN     = 3'd5;

    localparam int SQ_W     = 21;
    localparam int SQ_STEPS = 11;
    localparam int RND_W    = 11;

    // 50/283 as a scaled reciprocal: floor(rr * 50 / 283) = (rr * DIV_MUL) >> DIV_SHIFT.
    localparam int DIV_SHIFT = 25;
    localparam logic [22:0] DIV_MUL = 23'd5928345;

    localparam logic signed [9:0] STRONG_THR  = 10'sd10;
    localparam logic signed [9:0] SIGN_OFFSET = 10'sd127;
    localparam logic [2:0] CNT_MAX = 3'd7;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_STREAM = 2'd1;
    localparam logic [1:0] PH_DRAIN  = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] edge_byte;
        logic       last_of_run;
        logic       frame_end;
    } t_out_item;

endpackage

FILE: hdl/sobel_edge_byte_stream.sv
// Top level of the streaming 3x3 Sobel edge filter over interleaved image bytes.
// Depends on sobel_pkg and sobel_ram.
//
//  Channel   Signals                              Moves
//  in        i_in_valid / o_in_ready / i_in_data  one image byte or drain tick
//  out       o_out_valid / i_out_ready / o_out_data one result byte with flags
//  cfg       i_cfg_we / i_cfg_index / i_cfg_data  one register write, no wait
//
// One item is handled at a time: a first-row byte or ignored drain tick ends in S_START,
// other items write the lower row and then, per result, take the alpha, the signed or
// absolute, or the magnitude path, the last through the 11-step square root.
// The three row stores are single-port RAMs; their roles rotate at the end of each streamed row.
// After reset or a register write a setup pass runs before new input is taken.
// Reset is synchronous and active low. A stalled output holds the result register.
module sobel_edge_byte_stream #(
    parameter int MAX_WIDTH       = sobel_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PIXEL_BYTES = sobel_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sobel_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sobel_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]   i_cfg_data
);
    import sobel_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_PIXEL_BYTES;
    localparam int COL_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RB_W   = COL_W + 1;
    localparam int PB_W   = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int LANE_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int CW     = (RB_W > CFG_W) ? RB_W : CFG_W;
    localparam int PX     = (PB_W > 3) ? PB_W : 3;
    localparam int REM_W  = PB_W + 1;
    localparam int SC_W   = $clog2(COL_W + 1);
    localparam int SQC_W  = $clog2(SQ_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SYNC_INIT, S_SYNC_DIV, S_START, S_WLOW, S_RES, S_RDL, S_RDJ,
        S_RDR, S_CAPR, S_CALC, S_SQRT, S_RND, S_DIVS, S_OUT, S_FIN
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_cfg_w;
    logic [2:0]       r_cfg_pb;
    logic             r_cfg_alpha, r_cfg_hor, r_cfg_ver, r_cfg_sign;
    logic             r_sync_req;

    logic [PB_W-1:0]   r_p;
    logic [RB_W-1:0]   r_rb;
    logic [COL_W-1:0]  r_col;
    logic [LANE_W-1:0] r_lane;
    logic [1:0]        r_phase;
    logic [1:0]        r_rot;
    logic [2:0]        r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [SC_W-1:0]   r_sc;

    logic              r_op;
    logic [7:0]        r_px;
    logic              r_last;
    logic [COL_W-1:0]  r_j, r_al, r_ar;
    logic [LANE_W-1:0] r_jlane;
    logic [PB_W:0]     r_nres;
    logic              r_is_alpha;

    logic [7:0] r_up [3];
    logic [7:0] r_md [3];
    logic [7:0] r_lo [3];

    logic [SQ_W:0]      r_sq_n, r_sq_r, r_sq_bit;
    logic [SQC_W-1:0]   r_sq_cnt;
    logic [RND_W-1:0]   r_rr;
    logic signed [9:0]  r_grad;

    logic      r_out_valid;
    t_out_item r_out;

    // Effective configuration.
    logic [CW-1:0]      w_raw, w_eff;
    logic [PX-1:0]      p_raw, p_eff;
    logic [CW+PX-1:0]   rb_prod;
    logic [RB_W-1:0]    rb_new;

    always_comb begin
        w_raw = CW'(r_cfg_w);
        p_raw = PX'(r_cfg_pb);
        w_eff = w_raw;
        if (w_raw == '0) begin
            w_eff = CW'(1);
        end else if (w_raw > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end
        p_eff = p_raw;
        if (p_raw == '0) begin
            p_eff = PX'(1);
        end else if (p_raw > PX'(MAX_PIXEL_BYTES)) begin
            p_eff = PX'(MAX_PIXEL_BYTES);
        end
        rb_prod = (CW+PX)'(w_eff) * (CW+PX)'(p_eff);
        rb_new  = rb_prod[RB_W-1:0];
    end

    // Row store roles.
    logic [1:0] ph_up, ph_md, ph_lo;
    assign ph_up = r_rot;
    assign ph_md = (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
    assign ph_lo = (r_rot == 2'd0) ? 2'd2 : r_rot - 2'd1;

    logic [COL_W-1:0] ram_addr;
    logic [2:0]       ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rd [3];

    always_comb begin
        ram_we    = '0;
        ram_wdata = r_px;
        case (r_state)
            S_RDL:   ram_addr = r_al;
            S_RDJ:   ram_addr = r_j;
            S_RDR:   ram_addr = r_ar;
            default: ram_addr = r_col;
        endcase
        case (r_state)
            S_START: begin
                if (r_phase == PH_FIRST && !r_op) begin
                    ram_we[ph_up] = 1'b1;
                    ram_we[ph_md] = 1'b1;
                end
            end
            S_WLOW: begin
                ram_we[ph_lo] = 1'b1;
                if (r_phase == PH_DRAIN) begin
                    ram_wdata = ram_rd[ph_md];
                end
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        sobel_ram #(.WIDTH(8), .DEPTH(2 ** COL_W)) u_row (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_addr  (ram_addr),
            .i_wdata (ram_wdata),
            .o_rdata (ram_rd[g])
        );
    end

    // Position helpers.
    logic [CW-1:0] col_x, p_x, rb_x, j_x;
    logic          col_ge_p, col_last, j_ge_p, jr_in, lane_end, jlane_end;
    logic [LANE_W-1:0] lane_inc, jlane_inc;

    always_comb begin
        col_x     = CW'(r_col);
        p_x       = CW'(r_p);
        rb_x      = CW'(r_rb);
        j_x       = CW'(r_j);
        col_ge_p  = col_x >= p_x;
        col_last  = col_x == rb_x - CW'(1);
        j_ge_p    = j_x >= p_x;
        jr_in     = (j_x + p_x) < rb_x;
        lane_end  = CW'(r_lane) == p_x - CW'(1);
        jlane_end = CW'(r_jlane) == p_x - CW'(1);
        lane_inc  = lane_end ? '0 : r_lane + LANE_W'(1);
        jlane_inc = jlane_end ? '0 : r_jlane + LANE_W'(1);
    end

    // Gradient arithmetic on the captured neighbourhood.
    logic signed [11:0] grad_h, grad_v;
    logic signed [12:0] grad_s, grad_t, grad_a;
    logic signed [12:0] grad_q;
    logic signed [23:0] hh, vv;
    logic signed [9:0]  g_lin;

    always_comb begin
        grad_h = '0;
        grad_v = '0;
        if (r_cfg_hor) begin
            grad_h = (12'(r_up[0]) + {3'b0, r_up[1], 1'b0} + 12'(r_up[2]))
                   - (12'(r_lo[0]) + {3'b0, r_lo[1], 1'b0} + 12'(r_lo[2]));
        end
        if (r_cfg_ver) begin
            grad_v = (12'(r_up[0]) + {3'b0, r_md[0], 1'b0} + 12'(r_lo[0]))
                   - (12'(r_up[2]) + {3'b0, r_md[2], 1'b0} + 12'(r_lo[2]));
        end
        grad_s = 13'(grad_h) + 13'(grad_v);
        grad_t = grad_s + 13'sd4;
        grad_q = (grad_t < 0) ? -((-grad_t) >>> 3) : (grad_t >>> 3);
        grad_a = (grad_s < 0) ? -grad_s : grad_s;
        if (r_cfg_sign) begin
            g_lin = SIGN_OFFSET + 10'(grad_q);
        end else begin
            g_lin = 10'((grad_a + 13'sd2) >>> 2);
        end
        hh = 24'(grad_h) * 24'(grad_h);
        vv = 24'(grad_v) * 24'(grad_v);
    end

    logic [SQ_W:0]      sq_try;
    logic [RND_W+22:0]  div_prod;
    assign sq_try   = r_sq_r + r_sq_bit;
    assign div_prod = (RND_W+23)'(r_rr) * (RND_W+23)'(DIV_MUL);

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= CFG_W'(1);
            r_cfg_pb    <= 3'd4;
            r_cfg_alpha <= 1'b1;
            r_cfg_hor   <= 1'b1;
            r_cfg_ver   <= 1'b1;
            r_cfg_sign  <= 1'b1;
            r_sync_req  <= 1'b1;
            r_col       <= '0;
            r_lane      <= '0;
            r_phase     <= PH_FIRST;
            r_rot       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sync_req <= 1'b1;
                case (i_cfg_index)
                    CFG_WIDTH_PIXELS:  r_cfg_w     <= i_cfg_data;
                    CFG_PIXEL_BYTES:   r_cfg_pb    <= i_cfg_data[2:0];
                    CFG_HAS_ALPHA:     r_cfg_alpha <= i_cfg_data[0];
                    CFG_DO_HORIZONTAL: r_cfg_hor   <= i_cfg_data[0];
                    CFG_DO_VERTICAL:   r_cfg_ver   <= i_cfg_data[0];
                    CFG_KEEP_SIGN:     r_cfg_sign  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_sync_req) begin
                        r_state <= S_SYNC_INIT;
                    end else if (i_in_valid) begin
                        r_op    <= i_in_data.op;
                        r_px    <= i_in_data.pixel_byte;
                        r_state <= S_START;
                    end
                end
                S_SYNC_INIT: begin
                    if (!i_cfg_we) begin
                        r_sync_req <= 1'b0;
                    end
                    r_p        <= p_eff[PB_W-1:0];
                    r_rb       <= rb_new;
                    if (RB_W'(r_col) >= rb_new) begin
                        r_col <= COL_W'(rb_new - RB_W'(1));
                    end
                    r_rem   <= '0;
                    r_sc    <= SC_W'(COL_W);
                    r_state <= S_SYNC_DIV;
                end
                S_SYNC_DIV: begin
                    // Restoring remainder of the column by the pixel size, MSB first.
                    if (r_sc == '0) begin
                        r_lane  <= LANE_W'(r_rem);
                        r_state <= S_IDLE;
                    end else begin
                        if ({r_rem[REM_W-2:0], r_col[r_sc-SC_W'(1)]} >= REM_W'(r_p)) begin
                            r_rem <= {r_rem[REM_W-2:0], r_col[r_sc-SC_W'(1)]} - REM_W'(r_p);
                        end else begin
                            r_rem <= {r_rem[REM_W-2:0], r_col[r_sc-SC_W'(1)]};
                        end
                        r_sc <= r_sc - SC_W'(1);
                    end
                end
                S_START: begin
                    r_last <= col_last;
                    if (r_phase == PH_FIRST) begin
                        r_state <= S_IDLE;
                        if (!r_op) begin
                            if (col_last) begin
                                r_phase <= PH_STREAM;
                                r_col   <= '0;
                                r_lane  <= '0;
                            end else begin
                                r_col  <= r_col + COL_W'(1);
                                r_lane <= lane_inc;
                            end
                        end
                    end else begin
                        if (r_phase == PH_STREAM && r_op) begin
                            r_phase <= PH_DRAIN;
                        end
                        r_state <= S_WLOW;
                    end
                end
                S_WLOW: begin
                    if (col_ge_p) begin
                        r_j     <= r_col - COL_W'(r_p);
                        r_jlane <= r_lane;
                        r_nres  <= r_last ? (PB_W+1)'(r_p) + (PB_W+1)'(1) : (PB_W+1)'(1);
                        r_state <= S_RES;
                    end else if (r_last) begin
                        r_j     <= r_col + COL_W'(1) - COL_W'(r_p);
                        r_jlane <= '0;
                        r_nres  <= (PB_W+1)'(r_p);
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RES: begin
                    r_is_alpha <= r_cfg_alpha && jlane_end;
                    r_al       <= j_ge_p ? r_j - COL_W'(r_p) : r_j;
                    r_ar       <= jr_in ? r_j + COL_W'(r_p) : r_j;
                    r_state    <= (r_cfg_alpha && jlane_end) ? S_OUT : S_RDL;
                end
                S_RDL: r_state <= S_RDJ;
                S_RDJ: begin
                    r_up[0] <= ram_rd[ph_up];
                    r_md[0] <= ram_rd[ph_md];
                    r_lo[0] <= ram_rd[ph_lo];
                    r_state <= S_RDR;
                end
                S_RDR: begin
                    r_up[1] <= ram_rd[ph_up];
                    r_md[1] <= ram_rd[ph_md];
                    r_lo[1] <= ram_rd[ph_lo];
                    r_state <= S_CAPR;
                end
                S_CAPR: begin
                    r_up[2] <= ram_rd[ph_up];
                    r_md[2] <= ram_rd[ph_md];
                    r_lo[2] <= ram_rd[ph_lo];
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (r_cfg_hor && r_cfg_ver) begin
                        r_sq_n   <= (SQ_W+1)'(hh[SQ_W-1:0]) + (SQ_W+1)'(vv[SQ_W-1:0]);
                        r_sq_r   <= '0;
                        r_sq_bit <= (SQ_W+1)'(1) << (2 * (SQ_STEPS - 1));
                        r_sq_cnt <= SQC_W'(SQ_STEPS);
                        r_state  <= S_SQRT;
                    end else begin
                        r_grad  <= g_lin;
                        r_state <= S_OUT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_cnt == '0) begin
                        r_state <= S_RND;
                    end else begin
                        if (r_sq_n >= sq_try) begin
                            r_sq_n <= r_sq_n - sq_try;
                            r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                        end else begin
                            r_sq_r <= r_sq_r >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                        r_sq_cnt <= r_sq_cnt - SQC_W'(1);
                    end
                end
                S_RND: begin
                    r_rr    <= r_sq_r[RND_W-1:0] + RND_W'(r_sq_n > r_sq_r);
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_grad  <= 10'(div_prod[DIV_SHIFT+8:DIV_SHIFT]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.last_of_run <= r_nres == (PB_W+1)'(1);
                        r_out.frame_end   <= r_nres == (PB_W+1)'(1) && r_last
                                             && r_phase == PH_DRAIN;
                        if (r_is_alpha) begin
                            r_out.edge_byte <= (r_cnt != '0) ? 8'hFF : 8'h00;
                            r_cnt           <= '0;
                        end else begin
                            r_out.edge_byte <= r_grad[7:0];
                            if (r_grad > STRONG_THR && r_cnt < CNT_MAX) begin
                                r_cnt <= r_cnt + 3'd1;
                            end
                        end
                        if (r_nres == (PB_W+1)'(1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_nres  <= r_nres - (PB_W+1)'(1);
                            r_j     <= r_j + COL_W'(1);
                            r_jlane <= jlane_inc;
                            r_state <= S_RES;
                        end
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        r_col  <= '0;
                        r_lane <= '0;
                        if (r_phase == PH_DRAIN) begin
                            r_phase <= PH_FIRST;
                            r_cnt   <= '0;
                        end else begin
                            r_rot <= ph_md;
                        end
                    end else begin
                        r_col  <= r_col + COL_W'(1);
                        r_lane <= lane_inc;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_sync_req;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: hdl/sobel_ram.sv
// Generic single-port synchronous RAM with read-first behaviour.
// Read data is registered and appears in the cycle after the address. No dependencies.
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/sobel_chk.sv
// Port-level checker for the Sobel edge byte stream filter, bound to the top level.
// Depends on sobel_pkg and sobel_edge_byte_stream.
module sobel_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input sobel_pkg::t_out_item o_out_data
);
    import sobel_pkg::*;

    // A pending result transfer holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity straight after reset");

    // The end of the image always closes the run of its item.
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.last_of_run)
        else $error("frame end without last of run");

    // Items are taken one at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input transfer taken while an item is in progress");
endmodule

bind sobel_edge_byte_stream sobel_chk u_sobel_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/sv/tb_sobel_edge_byte_stream.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_byte_stream: random and directed image frames,
// a scoreboard class that predicts every result byte, and random stalls on both sides.
// Depends on sobel_pkg and the RTL of the filter.
module tb_sobel_edge_byte_stream;
    import sobel_pkg::*;

    localparam int ROW_DEPTH = MAX_WIDTH_DEF * MAX_PIXEL_BYTES_DEF;
    localparam int IDLE_LIMIT = 5000;

    class edge_scoreboard;
        logic [7:0] upper[ROW_DEPTH];
        logic [7:0] middle[ROW_DEPTH];
        logic [7:0] lower[ROW_DEPTH];
        int unsigned column;
        logic [1:0] phase;
        int unsigned strong_count;
        int unsigned regs[6];
        t_out_item pending[$];
        int fails;

        function void clear();
            column = 0;
            phase = PH_FIRST;
            strong_count = 0;
            regs = '{1, 4, 1, 1, 1, 1};
            pending.delete();
            fails = 0;
        endfunction

        function void set_reg(int idx, int unsigned val);
            regs[idx] = val;
        endfunction

        function int unsigned lanes();
            if (regs[CFG_PIXEL_BYTES] == 0) return 1;
            if (regs[CFG_PIXEL_BYTES] > MAX_PIXEL_BYTES_DEF) return MAX_PIXEL_BYTES_DEF;
            return regs[CFG_PIXEL_BYTES];
        endfunction

        function int unsigned row_bytes();
            int unsigned w;
            w = regs[CFG_WIDTH_PIXELS];
            if (w == 0) w = 1;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            return w * lanes();
        endfunction

        function int gradient(int unsigned j, int unsigned rb, int unsigned p);
            int unsigned lf, rt;
            int h, v;
            longint unsigned n, q, t;
            lf = (j >= p) ? j - p : j;
            rt = (j + p < rb) ? j + p : j;
            h = 0;
            v = 0;
            if (regs[CFG_DO_HORIZONTAL] != 0)
                h = (int'(upper[lf]) + 2 * int'(upper[j]) + int'(upper[rt]))
                  - (int'(lower[lf]) + 2 * int'(lower[j]) + int'(lower[rt]));
            if (regs[CFG_DO_VERTICAL] != 0)
                v = (int'(upper[lf]) + 2 * int'(middle[lf]) + int'(lower[lf]))
                  - (int'(upper[rt]) + 2 * int'(middle[rt]) + int'(lower[rt]));
            if (regs[CFG_DO_HORIZONTAL] != 0 && regs[CFG_DO_VERTICAL] != 0) begin
                n = h * h + v * v;
                q = 0;
                for (int b = 12; b >= 0; b--) begin
                    t = q | (64'd1 << b);
                    if (t * t <= n) q = t;
                end
                if (n >= q * q + q + 1) q = q + 1;
                return int'((50 * q) / 283);
            end
            if (regs[CFG_KEEP_SIGN] != 0) return 127 + (h + v + 4) / 8;
            return ((h + v < 0 ? -(h + v) : h + v) + 2) / 4;
        endfunction

        function void add_result(int unsigned j, int unsigned rb, int unsigned p);
            t_out_item r;
            int g;
            r = '0;
            if (regs[CFG_HAS_ALPHA] != 0 && (j % p) == p - 1) begin
                r.edge_byte = (strong_count != 0) ? 8'd255 : 8'd0;
                strong_count = 0;
            end else begin
                g = gradient(j, rb, p);
                r.edge_byte = g[7:0];
                if (g > 10 && strong_count < 7) strong_count++;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void note_input(t_in_item it);
            int unsigned p, rb, c, before_cnt;
            bit last;
            p = lanes();
            rb = row_bytes();
            if (column >= rb) column = rb - 1;
            c = column;
            last = (c == rb - 1);
            if (phase != PH_STREAM && phase != PH_DRAIN) begin
                if (it.op) return;
                upper[c] = it.pixel_byte;
                middle[c] = it.pixel_byte;
                if (last) begin
                    phase = PH_STREAM;
                    column = 0;
                end else begin
                    column++;
                end
                return;
            end
            if (phase == PH_STREAM && it.op) phase = PH_DRAIN;
            lower[c] = (phase == PH_DRAIN) ? middle[c] : it.pixel_byte;
            before_cnt = pending.size();
            if (c >= p) add_result(c - p, rb, p);
            if (last)
                for (int unsigned j = c + 1 - p; j <= c; j++) add_result(j, rb, p);
            if (last) begin
                if (phase == PH_DRAIN) begin
                    if (pending.size() > before_cnt) pending[pending.size() - 1].frame_end = 1'b1;
                    phase = PH_FIRST;
                    strong_count = 0;
                end else begin
                    for (int i = 0; i < ROW_DEPTH; i++) begin
                        upper[i] = middle[i];
                        middle[i] = lower[i];
                    end
                end
                column = 0;
            end else begin
                column++;
            end
            if (pending.size() > before_cnt) pending[pending.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_result(t_out_item act);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, act);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (act.edge_byte !== want.edge_byte) begin
                $display("%0t: edge_byte expected %0d actual %0d", $realtime,
                         want.edge_byte, act.edge_byte);
                fails++;
            end
            if (act.last_of_run !== want.last_of_run) begin
                $display("%0t: last_of_run expected %0b actual %0b", $realtime,
                         want.last_of_run, act.last_of_run);
                fails++;
            end
            if (act.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b", $realtime,
                         want.frame_end, act.frame_end);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WIDTH_PIXELS;
    logic [CFG_W-1:0] i_cfg_data = '0;

    edge_scoreboard board;
    bit quiet = 1'b0;
    int items_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    sobel_edge_byte_stream uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(bit op, logic [7:0] px);
        t_in_item it;
        int gap;
        it.op = op;
        it.pixel_byte = px;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(it);
        items_sent++;
        if (items_sent % 64 == 0) quiet = ~quiet;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned w, int unsigned p, bit a, bit h, bit v, bit k);
        int unsigned vals[6];
        vals = '{w, p, a, h, v, k};
        wait_idle();
        foreach (vals[i]) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data <= CFG_W'(vals[i]);
            board.set_reg(i, vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(bit extreme);
        if (extreme) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom);
    endfunction

    // One frame: first row, further image rows, then a closing row that turns into drain
    // at a random byte. A width change can be made in the middle of the second row.
    task automatic run_frame(int rows, bit extreme, bit shrink_mid);
        int unsigned rb, d, half;
        repeat ($urandom_range(0, 2)) send_item(1'b1, 8'($urandom));
        for (int r = 0; r < rows; r++) begin
            rb = board.row_bytes();
            if (shrink_mid && r == 1 && rb >= 4) begin
                half = rb / 2 + 1;
                for (int unsigned i = 0; i < half; i++) send_item(1'b0, pick_byte(extreme));
                set_config(1, board.regs[CFG_PIXEL_BYTES], $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
                rb = board.row_bytes();
                rb = (half >= rb) ? 1 : rb - half;
            end
            for (int unsigned i = 0; i < rb; i++) send_item(1'b0, pick_byte(extreme));
        end
        rb = board.row_bytes();
        d = $urandom_range(0, 3) == 0 ? $urandom_range(0, rb - 1) : 0;
        for (int unsigned i = 0; i < rb; i++)
            send_item(i < d ? 1'b0 : (i == d ? 1'b1 : 1'($urandom)), pick_byte(extreme));
    endtask

    initial begin : receiver
        int stall;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (!held && results_seen >= 150) begin
                stall = 400;
                held = 1'b1;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_result(o_out_data);
            results_seen++;
        end
    end

    initial begin : sender
        board = new();
        board.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_frame(1, 1'b1, 1'b0);
        set_config(0, 0, 1'b0, 1'b1, 1'b0, 1'b1);
        run_frame(2, 1'b1, 1'b0);
        set_config(2, 2, 1'b1, 1'b0, 1'b1, 1'b0);
        run_frame(1, 1'b1, 1'b0);
        set_config(3, 2, 1'b0, 1'b1, 1'b1, 1'b0);
        run_frame(2, 1'b0, 1'b1);
        set_config(2, 7, 1'b1, 1'b0, 1'b0, 1'b1);
        run_frame(1, 1'b0, 1'b0);

        while (items_sent < 480) begin
            set_config($urandom_range(0, 6), $urandom_range(0, 7), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
            run_frame($urandom_range(1, 4), $urandom_range(0, 5) == 0,
                      $urandom_range(0, 7) == 0);
        end

        set_config(0, 1, 1'b0, 1'b1, 1'b0, 1'b0);
        run_frame(1, 1'b0, 1'b0);

        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
